/* rtl/swcd_pkg.sv */
// ----------------------------------------------------------------------------
// swcd_pkg
// Types and constants shared by the wave column drawer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package swcd_pkg;

  localparam logic [7:0] SAMPLE_MIN   = 8'd32;
  localparam logic [7:0] SAMPLE_MAX   = 8'd159;
  localparam logic [7:0] COL_WRAP     = 8'd128;
  localparam logic [7:0] MARKER_BYTE  = 8'hFF;
  localparam logic [7:0] PAGE_CMD     = 8'hB0;
  localparam logic [7:0] COL_HI_CMD   = 8'h10;
  localparam logic [7:0] LOW_NIBBLE   = 8'h0F;
  localparam logic [7:0] TOP_BIT      = 8'b10000000;
  localparam logic [2:0] FIRST_PAGE   = 3'd4;

  // byte slot within one page group
  localparam logic [1:0] SLOT_PAGE    = 2'd0;
  localparam logic [1:0] SLOT_COL_HI  = 2'd1;
  localparam logic [1:0] SLOT_COL_LO  = 2'd2;
  localparam logic [1:0] SLOT_DATA    = 2'd3;

  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam logic [4:0] LAST_STEP = 5'd31;

  // one classified sample, ready to be drawn
  typedef struct packed {
    logic [1:0] page_idx;   // chosen page minus 4
    logic [7:0] bit_mask;   // single set bit on that page
    logic [7:0] col;        // wave column
  } desc_t;

endpackage

`default_nettype wire

/* rtl/scrolling_wave_column_drawer.sv */
// ----------------------------------------------------------------------------
// scrolling_wave_column_drawer
// Turns each sample into a 32-byte page-addressed display update.
// ----------------------------------------------------------------------------
// Each accepted sample yields 32 bytes: position commands and one data byte
// for pages 4..7 at the current column, then a solid marker column at the
// next column; out_last flags the 32nd byte. The output sequencer sends one
// byte per cycle while out_ready is held high, and samples stream back to
// back. A sample accepted into an empty block is first written into the
// queue and its first byte is then registered in the output register. A
// two-entry queue holds the sample being drawn until its last byte is
// loaded, so one further sample can be accepted while a stream is being
// sent; in_ready drops when both entries are taken.
`default_nettype none

module scrolling_wave_column_drawer (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_heart_rate,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_is_data,
  output logic [7:0]      out_byte,
  output logic            out_last
);

  logic            q_push, q_pop, q_full, q_empty;
  swcd_pkg::desc_t q_wdata, q_rdata;

  swcd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_heart_rate (in_heart_rate),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_wdata       (q_wdata)
  );

  swcd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .full  (q_full),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  swcd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .q_rdata     (q_rdata),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_is_data (out_is_data),
    .out_byte    (out_byte),
    .out_last    (out_last)
  );

endmodule

`default_nettype wire

/* rtl/swcd_front.sv */
// ----------------------------------------------------------------------------
// swcd_front
// Accepts samples, clamps and quantizes them, assigns the column.
// ----------------------------------------------------------------------------
`default_nettype none

module swcd_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [7:0]     in_heart_rate,
  input  wire logic           q_full,
  output logic                q_push,
  output swcd_pkg::desc_t     q_wdata
);

  logic [7:0] col_pos_r, col_pos_nxt;
  logic [7:0] clamped;
  logic [7:0] offs;
  logic [4:0] level;
  logic [7:0] col;

  always_comb begin
    if (in_heart_rate > swcd_pkg::SAMPLE_MAX)      clamped = swcd_pkg::SAMPLE_MAX;
    else if (in_heart_rate < swcd_pkg::SAMPLE_MIN) clamped = swcd_pkg::SAMPLE_MIN;
    else                                           clamped = in_heart_rate;
    offs  = clamped - swcd_pkg::SAMPLE_MIN;
    level = offs[6:2];
    col   = (col_pos_r == swcd_pkg::COL_WRAP) ? 8'd0 : col_pos_r;
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  // page = 7 - level/8, kept as offset from page 4
  assign q_wdata.page_idx = 2'd3 - level[4:3];
  assign q_wdata.bit_mask = swcd_pkg::TOP_BIT >> level[2:0];
  assign q_wdata.col      = col;

  assign col_pos_nxt = q_push ? col + 8'd1 : col_pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_pos_r <= 8'd0;
    end else begin
      col_pos_r <= col_pos_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/swcd_queue.sv */
// ----------------------------------------------------------------------------
// swcd_queue
// Short queue of classified samples between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module swcd_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire swcd_pkg::desc_t  wdata,
  input  wire logic             pop,
  output logic                  full,
  output logic                  empty,
  output swcd_pkg::desc_t       rdata
);

  swcd_pkg::desc_t mem_r [swcd_pkg::QDEPTH];

  logic [swcd_pkg::QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [swcd_pkg::QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [swcd_pkg::QCW-1:0] count_r, count_nxt;

  assign full  = (count_r == swcd_pkg::QCW'(swcd_pkg::QDEPTH));
  assign empty = (count_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == swcd_pkg::QAW'(swcd_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == swcd_pkg::QAW'(swcd_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop)      count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/swcd_back.sv */
// ----------------------------------------------------------------------------
// swcd_back
// Byte sequencer: expands one queued sample into the 32-byte stream.
// ----------------------------------------------------------------------------
`default_nettype none

module swcd_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_empty,
  input  wire swcd_pkg::desc_t  q_rdata,
  output logic                  q_pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  out_is_data,
  output logic [7:0]            out_byte,
  output logic                  out_last
);

  // step[4]: marker half, step[3:2]: page offset, step[1:0]: byte slot
  logic [4:0] step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       is_data_r, is_data_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic       last_r, last_nxt;

  logic       load;
  logic [7:0] cur_col;
  logic [2:0] page;

  assign load    = !q_empty && (!out_valid_r || out_ready);
  assign q_pop   = load && (step_r == swcd_pkg::LAST_STEP);
  assign cur_col = step_r[4] ? q_rdata.col + 8'd1 : q_rdata.col;
  assign page    = swcd_pkg::FIRST_PAGE + {1'b0, step_r[3:2]};

  always_comb begin
    is_data_nxt = 1'b0;
    case (step_r[1:0])
      swcd_pkg::SLOT_PAGE:   byte_nxt = swcd_pkg::PAGE_CMD + {5'd0, page};
      swcd_pkg::SLOT_COL_HI: byte_nxt = swcd_pkg::COL_HI_CMD | {4'd0, cur_col[7:4]};
      swcd_pkg::SLOT_COL_LO: byte_nxt = cur_col & swcd_pkg::LOW_NIBBLE;
      default: begin
        is_data_nxt = 1'b1;
        if (step_r[4])                            byte_nxt = swcd_pkg::MARKER_BYTE;
        else if (step_r[3:2] == q_rdata.page_idx) byte_nxt = q_rdata.bit_mask;
        else                                      byte_nxt = 8'h00;
      end
    endcase
    last_nxt = (step_r == swcd_pkg::LAST_STEP);

    if (load)           out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else                out_valid_nxt = out_valid_r;

    step_nxt = load ? step_r + 5'd1 : step_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      is_data_r <= is_data_nxt;
      byte_r    <= byte_nxt;
      last_r    <= last_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_is_data = is_data_r;
  assign out_byte    = byte_r;
  assign out_last    = last_r;

endmodule

`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Sample-to-display-stream check for the scrolling wave column drawer.
// ----------------------------------------------------------------------------
// Samples are queued by the stimulus block and sent by a valid/ready driver.
// Every accepted request is expanded by a column predictor into the 32
// expected display bytes. Each accepted output byte is checked against the
// oldest expected byte. Sender gaps and receiver stalls change per phase. One
// phase has a long receiver hold-off so that the block backs up.

module tb_top;

  localparam int CLK_HALF       = 10;
  localparam int RESET_CYCLES   = 12;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD      = 400;
  localparam int TAIL_CYCLES    = 40;
  localparam int PHASE_ITEMS    = 50;
  localparam int MAX_REPORTS    = 40;

  typedef struct {
    logic       is_data;
    logic [7:0] value;
    logic       last;
  } disp_byte_t;

  logic       clk;
  logic       rst_n         = 1'b0;
  logic       in_valid      = 1'b0;
  logic       in_ready;
  logic [7:0] in_heart_rate = 8'd0;
  logic       out_valid;
  logic       out_ready     = 1'b0;
  logic       out_is_data;
  logic [7:0] out_byte;
  logic       out_last;

  logic [7:0] sample_queue[$];
  disp_byte_t expected_bytes[$];
  logic [7:0] column_pos;
  int         send_idle_pct  = 0;
  int         recv_stall_pct = 0;
  bit         hold_start     = 1'b0;
  int         stall_left     = 0;
  int         mismatch_count = 0;
  int         idle_cycles    = 0;

  scrolling_wave_column_drawer i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_heart_rate(in_heart_rate),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_is_data  (out_is_data),
    .out_byte     (out_byte),
    .out_last     (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // column predictor
  // --------------------------------------------------------------------------
  function automatic void push_byte(input logic is_data, input logic [7:0] value);
    disp_byte_t b;
    b.is_data = is_data;
    b.value   = value;
    b.last    = 1'b0;
    expected_bytes.push_back(b);
  endfunction

  function automatic void push_position(input logic [7:0] col, input logic [2:0] page);
    push_byte(1'b0, swcd_pkg::PAGE_CMD + {5'd0, page});
    push_byte(1'b0, ((col & 8'hF0) >> 4) | swcd_pkg::COL_HI_CMD);
    push_byte(1'b0, col & swcd_pkg::LOW_NIBBLE);
  endfunction

  function automatic void predict_column(input logic [7:0] sample);
    logic [7:0] s;
    logic [7:0] diff;
    logic [4:0] level;
    logic [2:0] chosen_page;
    logic [7:0] mask;
    logic [7:0] col;
    logic [7:0] marker;
    int         p;
    if (column_pos == swcd_pkg::COL_WRAP) column_pos = 8'd0;
    s = sample;
    if (s > swcd_pkg::SAMPLE_MAX) s = swcd_pkg::SAMPLE_MAX;
    else if (s < swcd_pkg::SAMPLE_MIN) s = swcd_pkg::SAMPLE_MIN;
    diff        = s - swcd_pkg::SAMPLE_MIN;
    level       = diff[6:2];
    chosen_page = 3'd7 - {1'b0, level[4:3]};
    mask        = swcd_pkg::TOP_BIT >> level[2:0];
    col         = column_pos;
    marker      = col + 8'd1;
    for (p = 4; p < 8; p++) begin
      push_position(col, p[2:0]);
      push_byte(1'b1, (p[2:0] == chosen_page) ? mask : 8'h00);
    end
    for (p = 4; p < 8; p++) begin
      push_position(marker, p[2:0]);
      push_byte(1'b1, swcd_pkg::MARKER_BYTE);
    end
    expected_bytes[expected_bytes.size() - 1].last = 1'b1;
    column_pos = column_pos + 8'd1;
  endfunction

  // --------------------------------------------------------------------------
  // driver: sender side and receiver side
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid      <= 1'b0;
      in_heart_rate <= 8'd0;
    end else if (!in_valid || in_ready) begin
      if (sample_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid      <= 1'b1;
        in_heart_rate <= sample_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_start) begin
      hold_start = 1'b0;
      stall_left = LONG_HOLD;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // monitor: predict on input requests, check output bytes, watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    disp_byte_t exp_b;
    if (!rst_n) begin
      column_pos = 8'd0;
    end else begin
      if (in_valid && in_ready) predict_column(in_heart_rate);
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t: unexpected byte: expected none, actual %0b/%02h/%0b",
                     $time, out_is_data, out_byte, out_last);
        end else begin
          exp_b = expected_bytes.pop_front();
          if (out_is_data !== exp_b.is_data || out_byte !== exp_b.value ||
              out_last !== exp_b.last) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display("%0t: mismatch: expected %0b/%02h/%0b, actual %0b/%02h/%0b",
                       $time, exp_b.is_data, exp_b.value, exp_b.last,
                       out_is_data, out_byte, out_last);
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("Some tests failed");
          $finish;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  function automatic logic [7:0] rand_sample();
    logic [7:0] edges[6];
    int         r;
    edges = '{8'd0, 8'd31, 8'd32, 8'd159, 8'd160, 8'd255};
    r = $urandom_range(0, 9);
    if (r < 6) return 8'($urandom_range(32, 159));
    if (r < 8) return 8'($urandom_range(0, 255));
    return edges[$urandom_range(0, 5)];
  endfunction

  // sender holds off until every queued request is sent and every byte seen
  task automatic wait_drained();
    while (sample_queue.size() > 0 || in_valid || expected_bytes.size() > 0)
      @(negedge clk);
  endtask

  task automatic run_phase(input int n, input int send_pct, input int recv_pct,
                           input bit with_hold);
    int i;
    @(negedge clk);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (i = 0; i < n; i++) sample_queue.push_back(rand_sample());
    if (with_hold) hold_start = 1'b1;
    wait_drained();
  endtask

  initial begin
    logic [7:0] directed[$];
    directed = '{8'd0, 8'd255, 8'd31, 8'd32, 8'd33, 8'd35, 8'd36, 8'd159, 8'd160,
                 8'd158, 8'd155, 8'd64, 8'd63, 8'd95, 8'd96, 8'd127, 8'd128,
                 8'h55, 8'hAA, 8'd100, 8'd1};
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (directed[i]) sample_queue.push_back(directed[i]);
    wait_drained();

    run_phase(PHASE_ITEMS, 0, 0, 1'b1);
    run_phase(PHASE_ITEMS, 76, 0, 1'b0);
    run_phase(PHASE_ITEMS, 0, 76, 1'b0);
    run_phase(PHASE_ITEMS, 13, 13, 1'b0);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_bytes.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/swcd_pkg.sv
rtl/swcd_front.sv
rtl/swcd_queue.sv
rtl/swcd_back.sv
rtl/scrolling_wave_column_drawer.sv
dv/tb_top.sv
